>>> hw/rtl/t2d_pkg.sv
// Shared types, codes and the track 2 code table for the track 2 decoder.
package t2d_pkg;

  localparam int unsigned ResultsMax = 3;
  localparam logic [7:0] MaxCharsReset = 8'd47;
  localparam logic [3:0] GroupBits = 4'd5;
  localparam logic [3:0] ByteBits = 4'd8;
  localparam logic [6:0] CharBase = 7'd48;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusUnknown = 2'd1;
  localparam logic [1:0] StatusPartial = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] valid_bits;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] character;
    logic       char_valid;
    logic [1:0] status;
    logic       record_end;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] pos;
  } lookup_t;

  // 5-bit odd-parity group to table position
  function automatic lookup_t code_lookup(input logic [4:0] code);
    lookup_t r;
    r.hit = 1'b1;
    unique case (code)
      5'h01:   r.pos = 4'd0;
      5'h10:   r.pos = 4'd1;
      5'h08:   r.pos = 4'd2;
      5'h19:   r.pos = 4'd3;
      5'h04:   r.pos = 4'd4;
      5'h15:   r.pos = 4'd5;
      5'h0D:   r.pos = 4'd6;
      5'h1C:   r.pos = 4'd7;
      5'h02:   r.pos = 4'd8;
      5'h13:   r.pos = 4'd9;
      5'h0B:   r.pos = 4'd10;
      5'h1A:   r.pos = 4'd11;
      5'h07:   r.pos = 4'd12;
      5'h16:   r.pos = 4'd13;
      5'h0E:   r.pos = 4'd14;
      5'h1F:   r.pos = 4'd15;
      default: begin
        r.hit = 1'b0;
        r.pos = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/t2d_decode.sv
// Per-word decode logic and record state: bit gathering, group lookup, status.
module t2d_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  t2d_pkg::in_word_t           in_i,
  input  logic [7:0]                  max_chars_i,
  output t2d_pkg::result_t            res_o [t2d_pkg::ResultsMax],
  output logic [1:0]                  count_o
);
  import t2d_pkg::*;

  logic [3:0]  acc_q, acc_d;
  logic [2:0]  bits_q, bits_d;
  logic [7:0]  chars_q, chars_d;
  logic        disc_q, disc_d;

  logic [3:0]  nb;
  logic [11:0] acc;
  logic [11:0] sh1, sh2;
  logic [3:0]  held, held1, held_r;
  logic [7:0]  chars1, chars_r;
  lookup_t     lk1, lk2;
  logic        err;
  logic [1:0]  cnt;

  always_comb begin
    nb     = (in_i.valid_bits > ByteBits) ? ByteBits : in_i.valid_bits;
    acc    = ({8'd0, acc_q} << nb) | ({4'd0, in_i.data_byte} >> (ByteBits - nb));
    held   = {1'b0, bits_q} + nb;
    held1  = held - GroupBits;
    sh1    = acc >> held1;
    sh2    = acc >> (held1 - GroupBits);
    lk1    = code_lookup(sh1[4:0]);
    lk2    = code_lookup(sh2[4:0]);
    chars1 = chars_q + 8'd1;

    for (int i = 0; i < ResultsMax; i++) begin
      res_o[i] = '0;
    end
    cnt     = 2'd0;
    err     = 1'b0;
    held_r  = held;
    chars_r = chars_q;

    if (held >= GroupBits) begin
      if (chars_q >= max_chars_i) begin
        res_o[0] = '{character: '0, char_valid: 1'b0, status: StatusOverflow, record_end: 1'b1};
        cnt = 2'd1;
        err = 1'b1;
      end else if (!lk1.hit) begin
        res_o[0] = '{character: '0, char_valid: 1'b0, status: StatusUnknown, record_end: 1'b1};
        cnt = 2'd1;
        err = 1'b1;
      end else begin
        res_o[0] = '{character: CharBase + {3'd0, lk1.pos}, char_valid: 1'b1,
                     status: StatusOk, record_end: 1'b0};
        cnt     = 2'd1;
        chars_r = chars1;
        held_r  = held1;
        if (held1 >= GroupBits) begin
          if (chars1 >= max_chars_i) begin
            res_o[1] = '{character: '0, char_valid: 1'b0, status: StatusOverflow,
                         record_end: 1'b1};
            cnt = 2'd2;
            err = 1'b1;
          end else if (!lk2.hit) begin
            res_o[1] = '{character: '0, char_valid: 1'b0, status: StatusUnknown,
                         record_end: 1'b1};
            cnt = 2'd2;
            err = 1'b1;
          end else begin
            res_o[1] = '{character: CharBase + {3'd0, lk2.pos}, char_valid: 1'b1,
                         status: StatusOk, record_end: 1'b0};
            cnt     = 2'd2;
            chars_r = chars1 + 8'd1;
            held_r  = held1 - GroupBits;
          end
        end
      end
    end

    if (!err && in_i.last_byte) begin
      res_o[cnt] = '{character: '0, char_valid: 1'b0,
                     status: (held_r != 4'd0) ? StatusPartial : StatusOk, record_end: 1'b1};
      cnt = cnt + 2'd1;
    end

    count_o = disc_q ? 2'd0 : cnt;

    acc_d   = acc_q;
    bits_d  = bits_q;
    chars_d = chars_q;
    disc_d  = disc_q;
    if (fire_i) begin
      if (disc_q) begin
        if (in_i.last_byte) begin
          disc_d  = 1'b0;
          acc_d   = '0;
          bits_d  = '0;
          chars_d = '0;
        end
      end else if (err || in_i.last_byte) begin
        acc_d   = '0;
        bits_d  = '0;
        chars_d = '0;
        disc_d  = err && !in_i.last_byte;
      end else begin
        acc_d   = acc[3:0];
        bits_d  = held_r[2:0];
        chars_d = chars_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      bits_q  <= '0;
      chars_q <= '0;
      disc_q  <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      bits_q  <= bits_d;
      chars_q <= chars_d;
      disc_q  <= disc_d;
    end
  end

  a_residue_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !disc_q && !in_i.last_byte && !err |-> held_r <= 4'd4)
    else $error("t2d_decode: more than four bits left after decode");

endmodule

>>> hw/rtl/t2d_result_buf.sv
// Three-entry result register that drains one result word per cycle while the output side is ready.
module t2d_result_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  logic [1:0]                  count_i,
  input  t2d_pkg::result_t            res_i [t2d_pkg::ResultsMax],
  output t2d_pkg::result_t            out_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic                        can_load_o
);
  import t2d_pkg::*;

  result_t    res_q [ResultsMax];
  logic [1:0] rem_q, rem_d;
  logic       pop;

  assign valid_o    = (rem_q != 2'd0);
  assign out_o      = res_q[0];
  assign pop        = valid_o && ready_i;
  assign can_load_o = (rem_q == 2'd0) || ((rem_q == 2'd1) && ready_i);

  always_comb begin
    rem_d = rem_q;
    if (load_i) begin
      rem_d = count_i;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o)
    else $error("t2d_result_buf: load while results pending");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> rem_q == $past(count_i))
    else $error("t2d_result_buf: wrong result count after load");

  a_char_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_o.char_valid |-> !out_o.record_end && out_o.status == StatusOk)
    else $error("t2d_result_buf: character word carries status or end");

  a_close_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !out_o.char_valid |-> out_o.record_end && out_o.character == 7'd0)
    else $error("t2d_result_buf: status word malformed");

endmodule

>>> hw/rtl/track2_bit_stream_decoder_core.sv
// Top level of the track 2 magnetic-stripe bit stream decoder.
// Takes one stream byte per cycle when each byte yields at most one result word and the
// output side is ready; a byte that yields more result words (up to 3: two characters and
// the closing status) holds the input until the single output port has drained them from
// the three-entry result register. Bytes pass through in_q, then into the result register.
// Write max_chars via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
module track2_bit_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // max_chars
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] data_byte, [11:8] valid_bits, [15:12] zero
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [6:0] character, [8:7] status, [15:9] zero
  output logic        m_axis_tuser_o,  // char_valid
  output logic        m_axis_tlast_o   // record_end
);
  import t2d_pkg::*;

  logic [7:0] max_chars_q;
  in_word_t   in_q;
  logic       in_vld_q;
  logic       fire;
  logic       can_load;
  logic       s_accept;
  result_t    res [ResultsMax];
  logic [1:0] res_cnt;
  result_t    out_word;

  assign fire            = in_vld_q && can_load;
  assign s_axis_tready_o = !in_vld_q || fire;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= MaxCharsReset;
    end else if (cfg_we_i) begin
      max_chars_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q.data_byte  <= s_axis_tdata_i[7:0];
      in_q.valid_bits <= s_axis_tdata_i[11:8];
      in_q.last_byte  <= s_axis_tlast_i;
    end
  end

  t2d_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .in_i        (in_q),
    .max_chars_i (max_chars_q),
    .res_o       (res),
    .count_o     (res_cnt)
  );

  t2d_result_buf u_result_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .count_i    (res_cnt),
    .res_i      (res),
    .out_o      (out_word),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .can_load_o (can_load)
  );

  assign m_axis_tdata_o = {7'd0, out_word.status, out_word.character};
  assign m_axis_tuser_o = out_word.char_valid;
  assign m_axis_tlast_o = out_word.record_end;

endmodule
